@@ src/assert_macros.svh @@
// Assertion helpers for the top-level RTL file of the record table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSRU_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lsru assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LSRU_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lsru assertion failed");

`endif

@@ src/lsru_pkg.sv @@
// ----------------------------------------------------------------------------
// lsru_pkg
// Shared types and constants for the sorted last-writer-wins record table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsru_pkg;

  // Default number of records in the table.
  localparam int unsigned LSRU_TABLE_DEPTH = 256;

  // Record geometry.
  localparam int unsigned KEY_BYTES     = 16;
  localparam int unsigned PAYLOAD_BYTES = 48;
  localparam int unsigned HALF_KEY_W    = KEY_BYTES * 4;
  localparam int unsigned PAYLOAD_WORDS = PAYLOAD_BYTES / 8;
  localparam int unsigned WORD_W        = 64;
  localparam int unsigned SLOT_W        = 8;
  localparam int unsigned COUNT_W       = 9;

  typedef logic [WORD_W-1:0] word_t;

  // One upsert request.
  typedef struct packed {
    logic [HALF_KEY_W-1:0] key_high;
    logic [HALF_KEY_W-1:0] key_low;
    word_t                 write_stamp;
    logic                  deleted_mark;
    word_t                 payload_word_0;
    word_t                 payload_word_1;
    word_t                 payload_word_2;
    word_t                 payload_word_3;
    word_t                 payload_word_4;
    word_t                 payload_word_5;
  } in_item_t;

  // One upsert outcome.
  typedef struct packed {
    logic               accepted;
    logic               was_new;
    logic               full_reject;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] entry_count;
  } out_item_t;

  // One stored record, a single row of the record memory.
  typedef struct packed {
    logic [HALF_KEY_W-1:0]               key_high;
    logic [HALF_KEY_W-1:0]               key_low;
    word_t                               stamp;
    logic                                tombstone;
    logic [PAYLOAD_WORDS-1:0][WORD_W-1:0] payload;
  } record_t;

  // Outcome of the shared comparator.
  typedef struct packed {
    logic key_lt;    // stored key below the probe key
    logic key_eq;    // stored key equal to the probe key
    logic stamp_gt;  // probe stamp strictly above the stored stamp
  } cmp_res_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_SHIFT,
    S_DRAIN,
    S_PLACE,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

@@ src/lww_sorted_record_upsert_top.sv @@
// ----------------------------------------------------------------------------
// lww_sorted_record_upsert_top
// Sorted record table keyed by 128 bits with last-writer-wins upserts.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o   in_item_i  (in_item_t)
//   out      output     out_valid_o/out_ready_i out_item_o (out_item_t)
//
// One item at a time: accept, at most log2(N)+1 probes, each a read and a
// compare, one closing probe step when the key is absent, then the finish.
// An insert moves every later record up one row per cycle, drains the last
// move and places the record; with no later record it only places it.
// Reset clears the record count and all control state; no clearing pass runs.
// The finish waits for the previous result to be taken, but not the search.
//
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lww_sorted_record_upsert_top
  import lsru_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = LSRU_TABLE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  record_t       rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  record_t       wr_data;

  // Sequencer.
  lsru_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  // Record memory.
  lsru_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // An accepted item keeps the block busy for at least the next cycle.
  `LSRU_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // A full table rejects only new keys and leaves the table unchanged.
  `LSRU_ASSERT_IMP(a_full_is_new, clk_i, rst_ni, out_valid_o && out_item_o.full_reject,
                   out_item_o.was_new && !out_item_o.accepted)

  // A successful insert always leaves at least one record counted.
  `LSRU_ASSERT_IMP(a_insert_counts, clk_i, rst_ni,
                   out_valid_o && out_item_o.accepted && out_item_o.was_new,
                   out_item_o.entry_count != '0)

endmodule

`default_nettype wire

@@ src/lsru_cmp.sv @@
// ----------------------------------------------------------------------------
// lsru_cmp
// Shared key and timestamp comparator used by every search step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsru_cmp
  import lsru_pkg::*;
(
  input  record_t  stored_i,
  input  in_item_t probe_i,
  output cmp_res_t res_o
);

  logic high_eq;
  logic high_lt;
  logic low_lt;

  // Key halves compared unsigned, high half most significant.
  always_comb begin
    high_eq         = (stored_i.key_high == probe_i.key_high);
    high_lt         = (stored_i.key_high < probe_i.key_high);
    low_lt          = (stored_i.key_low < probe_i.key_low);
    res_o.key_eq    = high_eq && (stored_i.key_low == probe_i.key_low);
    res_o.key_lt    = high_lt || (high_eq && low_lt);
    res_o.stamp_gt  = (probe_i.write_stamp > stored_i.stamp);
  end

endmodule

`default_nettype wire

@@ src/lsru_mem.sv @@
// ----------------------------------------------------------------------------
// lsru_mem
// Record memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsru_mem
  import lsru_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = LSRU_TABLE_DEPTH,
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [IW-1:0] rd_addr_i,
  output record_t       rd_data_o,
  input  logic          wr_en_i,
  input  logic [IW-1:0] wr_addr_i,
  input  record_t       wr_data_i
);

  record_t mem_q [TABLE_DEPTH];
  record_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ src/lsru_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsru_ctrl
// Sequencer: binary search over the record memory, update or shifted insert,
// and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsru_ctrl
  import lsru_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = LSRU_TABLE_DEPTH,
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  in_item_t      in_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output out_item_t     out_item_o,
  output logic          rd_en_o,
  output logic [IW-1:0] rd_addr_o,
  input  record_t       rd_data_i,
  output logic          wr_en_o,
  output logic [IW-1:0] wr_addr_o,
  output record_t       wr_data_o
);

  state_e state_q, state_d;

  logic [CW-1:0] held_q, held_d;
  logic          out_valid_q, out_valid_d;
  logic          wr_pend_q, wr_pend_d;

  in_item_t      item_q, item_d;
  logic [CW-1:0] left_q, left_d;
  logic [CW-1:0] right_q, right_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [IW-1:0] mid_q, mid_d;
  logic [IW-1:0] ri_q, ri_d;
  logic [IW-1:0] wr_addr_q, wr_addr_d;
  logic          acc_q, acc_d;
  logic          new_q, new_d;
  logic          full_q, full_d;
  out_item_t     out_q, out_d;

  cmp_res_t      cmp;
  logic [CW-1:0] mid_w;
  logic [CW-1:0] held_m1;
  logic          span_open;
  logic          held_full;
  logic          ri_at_pos;
  logic          out_free;
  record_t       new_rec;

  // Shared comparator: stored row against the item being worked on.
  lsru_cmp u_cmp (
    .stored_i (rd_data_i),
    .probe_i  (item_q),
    .res_o    (cmp)
  );

  // Search and shift bookkeeping.
  always_comb begin
    mid_w     = left_q + ((right_q - left_q) >> 1);
    held_m1   = held_q - CW'(1);
    span_open = (left_q < right_q);
    held_full = (held_q == CW'(TABLE_DEPTH));
    ri_at_pos = (CW'(ri_q) == pos_q);
    out_free  = !out_valid_q || out_ready_i;
  end

  // Record built from the latched item.
  always_comb begin
    new_rec.key_high   = item_q.key_high;
    new_rec.key_low    = item_q.key_low;
    new_rec.stamp      = item_q.write_stamp;
    new_rec.tombstone  = item_q.deleted_mark;
    new_rec.payload[0] = item_q.payload_word_0;
    new_rec.payload[1] = item_q.payload_word_1;
    new_rec.payload[2] = item_q.payload_word_2;
    new_rec.payload[3] = item_q.payload_word_3;
    new_rec.payload[4] = item_q.payload_word_4;
    new_rec.payload[5] = item_q.payload_word_5;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (span_open) begin
          state_d = S_CMP;
        end else if (held_full) begin
          state_d = S_DONE;
        end else if (left_q == held_q) begin
          state_d = S_PLACE;
        end else begin
          state_d = S_SHIFT;
        end
      end
      S_CMP: begin
        if (cmp.key_eq) begin
          state_d = S_DONE;
        end else begin
          state_d = S_PROBE;
        end
      end
      S_SHIFT: begin
        if (ri_at_pos) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_PLACE;
      S_PLACE: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake and memory port outputs.
  always_comb begin
    in_ready_o = 1'b0;
    rd_en_o    = 1'b0;
    rd_addr_o  = mid_w[IW-1:0];
    wr_en_o    = 1'b0;
    wr_addr_o  = wr_addr_q;
    wr_data_o  = rd_data_i;
    case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_PROBE: rd_en_o = span_open;
      S_CMP: begin
        wr_en_o   = cmp.key_eq && cmp.stamp_gt;
        wr_addr_o = mid_q;
        wr_data_o = new_rec;
      end
      S_SHIFT: begin
        rd_en_o   = 1'b1;
        rd_addr_o = ri_q;
        wr_en_o   = wr_pend_q;
      end
      S_DRAIN: wr_en_o = 1'b1;
      S_PLACE: begin
        wr_en_o   = 1'b1;
        wr_addr_o = pos_q[IW-1:0];
        wr_data_o = new_rec;
      end
      default: ;
    endcase
  end

  // Datapath next values.
  always_comb begin
    held_d      = held_q;
    wr_pend_d   = 1'b0;
    item_d      = item_q;
    left_d      = left_q;
    right_d     = right_q;
    pos_d       = pos_q;
    mid_d       = mid_q;
    ri_d        = ri_q;
    wr_addr_d   = wr_addr_q;
    acc_d       = acc_q;
    new_d       = new_q;
    full_d      = full_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          left_d  = '0;
          right_d = held_q;
          acc_d   = 1'b0;
          new_d   = 1'b0;
          full_d  = 1'b0;
        end
      end
      S_PROBE: begin
        if (span_open) begin
          mid_d = mid_w[IW-1:0];
        end else begin
          pos_d  = left_q;
          new_d  = 1'b1;
          full_d = held_full;
          ri_d   = held_m1[IW-1:0];
        end
      end
      S_CMP: begin
        if (cmp.key_eq) begin
          pos_d = CW'(mid_q);
          acc_d = cmp.stamp_gt;
        end else if (cmp.key_lt) begin
          left_d = CW'(mid_q) + CW'(1);
        end else begin
          right_d = CW'(mid_q);
        end
      end
      S_SHIFT: begin
        // Read the row below, write the row read last cycle one place up.
        wr_pend_d = 1'b1;
        wr_addr_d = ri_q + IW'(1);
        if (!ri_at_pos) begin
          ri_d = ri_q - IW'(1);
        end
      end
      S_PLACE: begin
        held_d = held_q + CW'(1);
        acc_d  = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_d.accepted    = acc_q;
          out_d.was_new     = new_q;
          out_d.full_reject = full_q;
          out_d.slot        = (32'(pos_q) > 32'd255) ? {SLOT_W{1'b1}} : SLOT_W'(pos_q);
          out_d.entry_count = COUNT_W'(held_q);
          out_valid_d       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      wr_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
      wr_pend_q   <= wr_pend_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    left_q    <= left_d;
    right_q   <= right_d;
    pos_q     <= pos_d;
    mid_q     <= mid_d;
    ri_q      <= ri_d;
    wr_addr_q <= wr_addr_d;
    acc_q     <= acc_d;
    new_q     <= new_d;
    full_q    <= full_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted last-writer-wins record table: upserts
// are predicted against a local copy of the table and every outcome checked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lsru_pkg::*;

  localparam int unsigned TABLE_ROWS = LSRU_TABLE_DEPTH;
  localparam logic [63:0] ALL_ONES   = '1;

  typedef enum int {PAY_RANDOM, PAY_ZERO, PAY_ONES} pay_fill_e;

  // Local copy of the record table plus the queue of outcomes still due.
  class upsert_scoreboard;
    record_t     rows [TABLE_ROWS];
    int unsigned held;
    out_item_t   due_outcomes [$];
    int unsigned failures;

    function new();
      held     = 0;
      failures = 0;
    endfunction

    // Applies one accepted upsert to the table and queues its outcome.
    function void note_upsert(in_item_t it);
      logic [127:0] probe;
      logic [127:0] row_key;
      int unsigned  lo_i;
      int unsigned  hi_i;
      int unsigned  mid;
      int unsigned  pos;
      bit           found;
      out_item_t    want;
      probe = {it.key_high, it.key_low};
      lo_i  = 0;
      hi_i  = held;
      pos   = 0;
      found = 1'b0;
      want  = '0;
      // Binary search over the records held so far.
      while (lo_i < hi_i) begin
        mid     = lo_i + (hi_i - lo_i) / 2;
        row_key = {rows[mid].key_high, rows[mid].key_low};
        if (row_key == probe) begin
          found = 1'b1;
          pos   = mid;
          break;
        end
        if (row_key < probe) begin
          lo_i = mid + 1;
        end else begin
          hi_i = mid;
        end
      end
      if (!found) pos = lo_i;

      if (found) begin
        // Only a strictly newer stamp replaces the stored record.
        if (it.write_stamp > rows[pos].stamp) begin
          rows[pos].stamp      = it.write_stamp;
          rows[pos].tombstone  = it.deleted_mark;
          rows[pos].payload[0] = it.payload_word_0;
          rows[pos].payload[1] = it.payload_word_1;
          rows[pos].payload[2] = it.payload_word_2;
          rows[pos].payload[3] = it.payload_word_3;
          rows[pos].payload[4] = it.payload_word_4;
          rows[pos].payload[5] = it.payload_word_5;
          want.accepted = 1'b1;
        end
      end else begin
        want.was_new = 1'b1;
        if (held >= TABLE_ROWS) begin
          want.full_reject = 1'b1;
        end else begin
          // Open a gap at the insertion point and place the new record.
          for (int i = held; i > pos; i--) rows[i] = rows[i-1];
          rows[pos].key_high   = it.key_high;
          rows[pos].key_low    = it.key_low;
          rows[pos].stamp      = it.write_stamp;
          rows[pos].tombstone  = it.deleted_mark;
          rows[pos].payload[0] = it.payload_word_0;
          rows[pos].payload[1] = it.payload_word_1;
          rows[pos].payload[2] = it.payload_word_2;
          rows[pos].payload[3] = it.payload_word_3;
          rows[pos].payload[4] = it.payload_word_4;
          rows[pos].payload[5] = it.payload_word_5;
          held++;
          want.accepted = 1'b1;
        end
      end
      want.slot        = (pos > 255) ? 8'd255 : pos[7:0];
      want.entry_count = held[8:0];
      due_outcomes.push_back(want);
    endfunction

    // Compares one delivered outcome with the oldest one due.
    function void check_outcome(out_item_t got);
      out_item_t want;
      if (due_outcomes.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: outcome with none due: acc %0d new %0d full %0d slot %0d count %0d",
                   $realtime, got.accepted, got.was_new, got.full_reject, got.slot,
                   got.entry_count);
        return;
      end
      want = due_outcomes.pop_front();
      if (got.accepted !== want.accepted || got.was_new !== want.was_new ||
          got.full_reject !== want.full_reject || got.slot !== want.slot ||
          got.entry_count !== want.entry_count) begin
        failures++;
        if (failures <= 10)
          $display({"%0t: outcome mismatch (expected/actual): acc %0d/%0d new %0d/%0d ",
                    "full %0d/%0d slot %0d/%0d count %0d/%0d"}, $realtime,
                   want.accepted, got.accepted, want.was_new, got.was_new,
                   want.full_reject, got.full_reject, want.slot, got.slot,
                   want.entry_count, got.entry_count);
      end
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  upsert_scoreboard sb;
  bit               calm = 1'b0;
  int unsigned      ready_hold = 0;

  lww_sorted_record_upsert_top #(
    .TABLE_DEPTH(TABLE_ROWS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // Free-running clock.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly short gaps, now and then a long one, none during a calm stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic in_item_t make_item(logic [63:0] kh, logic [63:0] kl,
                                         logic [63:0] st, logic del, pay_fill_e fill);
    in_item_t it;
    it.key_high     = kh;
    it.key_low      = kl;
    it.write_stamp  = st;
    it.deleted_mark = del;
    case (fill)
      PAY_ZERO: begin
        {it.payload_word_0, it.payload_word_1, it.payload_word_2} = '0;
        {it.payload_word_3, it.payload_word_4, it.payload_word_5} = '0;
      end
      PAY_ONES: begin
        {it.payload_word_0, it.payload_word_1, it.payload_word_2} = '1;
        {it.payload_word_3, it.payload_word_4, it.payload_word_5} = '1;
      end
      default: begin
        it.payload_word_0 = rand64();
        it.payload_word_1 = rand64();
        it.payload_word_2 = rand64();
        it.payload_word_3 = rand64();
        it.payload_word_4 = rand64();
        it.payload_word_5 = rand64();
      end
    endcase
    return it;
  endfunction

  // Mostly new keys, some near or sharing a half with stored ones, the rest
  // rewrites of stored keys with equal, older or newer stamps.
  function automatic in_item_t next_random_item();
    int unsigned idx;
    logic [63:0] kh;
    logic [63:0] kl;
    logic [63:0] st;
    if (sb.held == 0 || $urandom_range(0, 99) < 65) begin
      idx = (sb.held == 0) ? 0 : $urandom_range(0, sb.held - 1);
      kh  = rand64();
      kl  = rand64();
      if (sb.held != 0) begin
        case ($urandom_range(0, 3))
          0: kh = sb.rows[idx].key_high;
          1: begin
            kh = sb.rows[idx].key_high;
            kl = sb.rows[idx].key_low + 64'd1;
          end
          default: ;
        endcase
      end
      return make_item(kh, kl, rand64(), 1'($urandom_range(0, 1)), PAY_RANDOM);
    end
    idx = $urandom_range(0, sb.held - 1);
    st  = sb.rows[idx].stamp;
    case ($urandom_range(0, 3))
      0: ;
      1: if (st != ALL_ONES) st = st + 64'd1;
      2: st = st >> 1;
      default: st = rand64();
    endcase
    return make_item(sb.rows[idx].key_high, sb.rows[idx].key_low, st,
                     1'($urandom_range(0, 1)), PAY_RANDOM);
  endfunction

  // Presents one item, holds it until taken, then idles for a random gap.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_upsert(it);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the sender back until every outcome due has been delivered.
  task automatic wait_for_outcomes();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.due_outcomes.size() != 0);
  endtask

  // Receiver: random back-pressure, and checking of each delivered item.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_outcome(out_item_o);
    if (ready_hold != 0) begin
      out_ready_i <= 1'b0;
      ready_hold  = ready_hold - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0)
        ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(1, 3);
    end
  end

  // Hang guard.
  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus.
  initial begin
    int unsigned n;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes of key, stamp and payload, equal and older stamps, and keys
    // that differ only in one half.
    calm = 1'b1;
    send_item(make_item('0, '0, '0, 1'b0, PAY_ZERO));
    send_item(make_item('0, '0, '0, 1'b1, PAY_ONES));
    send_item(make_item('0, '0, ALL_ONES, 1'b1, PAY_ONES));
    send_item(make_item('0, '0, 64'd5, 1'b0, PAY_RANDOM));
    calm = 1'b0;
    send_item(make_item(ALL_ONES, '0, 64'd1, 1'b0, PAY_RANDOM));
    send_item(make_item('0, ALL_ONES, 64'd7, 1'b1, PAY_RANDOM));
    send_item(make_item(ALL_ONES, '0, 64'd1, 1'b1, PAY_ZERO));
    send_item(make_item(ALL_ONES, '0, 64'd2, 1'b1, PAY_ONES));
    send_item(make_item(ALL_ONES, '0, 64'd0, 1'b0, PAY_RANDOM));
    send_item(make_item(64'd1, '0, ALL_ONES, 1'b0, PAY_RANDOM));
    send_item(make_item('0, 64'd1, 64'd3, 1'b0, PAY_RANDOM));
    send_item(make_item(64'd1, ALL_ONES, 64'd9, 1'b1, PAY_RANDOM));
    send_item(make_item(64'd1, '0, ALL_ONES, 1'b1, PAY_RANDOM));
    send_item(make_item('0, ALL_ONES, 64'd8, 1'b0, PAY_ONES));
    send_item(make_item(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                        64'h8000_0000_0000_0000, 1'b1, PAY_RANDOM));
    send_item(make_item(64'h7FFF_FFFF_FFFF_FFFF, ALL_ONES, 64'd4, 1'b0, PAY_RANDOM));
    wait_for_outcomes();

    // Random upserts until the table has filled and rejects have piled up.
    n = 0;
    while (n < 500 || sb.held < TABLE_ROWS) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == 250) wait_for_outcomes();
      send_item(next_random_item());
      n++;
    end
    calm = 1'b0;
    wait_for_outcomes();

    // Full table: a key above every stored one saturates the slot, a random
    // new key is rejected, and stored keys can still be rewritten.
    send_item(make_item(ALL_ONES, ALL_ONES, 64'd1, 1'b1, PAY_RANDOM));
    send_item(make_item(rand64(), rand64(), rand64(), 1'b0, PAY_RANDOM));
    send_item(make_item(sb.rows[TABLE_ROWS-1].key_high, sb.rows[TABLE_ROWS-1].key_low,
                        ALL_ONES, 1'b0, PAY_ONES));
    send_item(make_item(sb.rows[0].key_high, sb.rows[0].key_low, '0, 1'b1, PAY_ZERO));
    send_item(make_item(sb.rows[TABLE_ROWS/2].key_high, sb.rows[TABLE_ROWS/2].key_low,
                        sb.rows[TABLE_ROWS/2].stamp, 1'b0, PAY_RANDOM));

    // Let the last outcomes arrive, then watch for stray ones.
    wait_for_outcomes();
    repeat (300) @(posedge clk_i);
    if (sb.failures == 0 && sb.due_outcomes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
